// File: design/delimiter_stream_splitter_defines.svh
// Assertion macros for the checker file.
`ifndef DELIMITER_STREAM_SPLITTER_DEFINES_SVH
`define DELIMITER_STREAM_SPLITTER_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define DSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/dss_pkg.sv
// Shared constants, types and helper functions of the delimiter stream splitter.
package dss_pkg;

    localparam int MAX_DELIM = 8;
    localparam int BYTE_W    = 8;
    localparam int DELIM_W   = MAX_DELIM * BYTE_W;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 2'd1;

    localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET  = 64'd10;
    localparam logic [LEN_W-1:0]   DELIM_LENGTH_RESET = 4'd1;

    // What follows the prefix flush of one command.
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_END  = 2'd1;
    localparam logic [1:0] TAIL_DATA = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [1:0]        tail;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_DELIM)) begin
            res = LEN_W'(MAX_DELIM);
        end
        return res;
    endfunction

    function automatic logic [BYTE_W-1:0] delim_at(input logic [DELIM_W-1:0] bytes,
                                                   input logic [CNT_W-1:0] idx);
        return bytes[{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

// File: design/delimiter_stream_splitter.sv
// Top level of the delimiter stream splitter: configuration registers and wiring.
//
// Input channel: i_in_valid / o_in_stall carry one beat of i_data_byte and
// i_end_of_input. A beat is a stream byte, or with i_end_of_input set the
// end of the stream, which flushes a held partial delimiter and closes an
// open segment.
// Output channel: o_out_valid / i_out_stall carry result beats: a data byte
// (o_byte_valid) or a segment end marker (o_segment_end). o_last marks the
// final result caused by one input beat; an input beat gives 0 to 8 results.
// Configuration: i_cfg_valid / o_cfg_ready write register i_cfg_index with
// i_cfg_data (0: delimiter bytes, first byte lowest; 1: delimiter length).
// o_cfg_ready is always high. Write only while the block is idle.
// Path: command queue, back-end command register, then the output register.
// Throughput: the back end delivers one result per cycle while i_out_stall is
// low; the front end takes one beat per cycle while its two-entry command queue
// has room. The back end's single result register sets the sustained rate.
// Reset clears the match state, the queue and the output valid, and loads a
// single newline delimiter. A stall on the output holds the result beat and
// backs up through the queue to o_in_stall.
module delimiter_stream_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dss_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                            i_end_of_input,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [dss_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_segment_end,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dss_pkg::DELIM_W-1:0]     i_cfg_data
);

    logic [dss_pkg::DELIM_W-1:0] r_delim_bytes;
    logic [dss_pkg::LEN_W-1:0]   r_delim_length;
    dss_pkg::t_q_stat            q_stat;
    dss_pkg::t_cmd               push_cmd;
    dss_pkg::t_cmd               head_cmd;
    logic                        push;
    logic                        pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes  <= dss_pkg::DELIM_BYTES_RESET;
            r_delim_length <= dss_pkg::DELIM_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Ignore writes beyond the register list.
            if (i_cfg_index == dss_pkg::REG_DELIM_BYTES) begin
                r_delim_bytes <= i_cfg_data;
            end else if (i_cfg_index == dss_pkg::REG_DELIM_LENGTH) begin
                r_delim_length <= i_cfg_data[dss_pkg::LEN_W-1:0];
            end
        end
    end

    dss_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_delim_bytes  (r_delim_bytes),
        .i_delim_length (r_delim_length),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    dss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    dss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_cmd),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .i_delim_bytes (r_delim_bytes),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_segment_end (o_segment_end),
        .o_last        (o_last)
    );

endmodule

// File: design/dss_front.sv
// Front end: accepts input beats, tracks the delimiter match and issues commands.
module dss_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dss_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_end_of_input,
    input  logic [dss_pkg::DELIM_W-1:0]   i_delim_bytes,
    input  logic [dss_pkg::LEN_W-1:0]     i_delim_length,
    input  dss_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output dss_pkg::t_cmd                 o_cmd
);

    logic [dss_pkg::CNT_W-1:0] r_match_count, n_match_count;
    logic                      r_segment_open, n_segment_open;
    logic [dss_pkg::LEN_W-1:0] len;
    logic [dss_pkg::LEN_W-1:0] m0;
    logic [dss_pkg::LEN_W-1:0] m1;
    logic                      accept;
    dss_pkg::t_cmd             cmd;

    assign accept     = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;

    always_comb begin
        len            = dss_pkg::used_length(i_delim_length);
        cmd.cnt        = '0;
        cmd.tail       = dss_pkg::TAIL_NONE;
        cmd.data       = i_data_byte;
        n_match_count  = r_match_count;
        n_segment_open = r_segment_open;
        m0             = {1'b0, r_match_count};
        m1             = m0 + 4'd1;
        if (i_end_of_input) begin
            cmd.cnt        = r_match_count;
            cmd.tail       = (r_segment_open || r_match_count != '0) ?
                             dss_pkg::TAIL_END : dss_pkg::TAIL_NONE;
            n_match_count  = '0;
            n_segment_open = 1'b0;
        end else begin
            // Delimiter shrank under a held prefix: flush it and start over.
            if (m0 >= len) begin
                cmd.cnt        = r_match_count;
                n_segment_open = 1'b1;
                m0             = '0;
            end
            m1 = m0 + 4'd1;
            if (i_data_byte == dss_pkg::delim_at(i_delim_bytes, m0[dss_pkg::CNT_W-1:0])) begin
                if (m1 >= len) begin
                    cmd.tail       = dss_pkg::TAIL_END;
                    n_match_count  = '0;
                    n_segment_open = 1'b0;
                end else begin
                    n_match_count = m1[dss_pkg::CNT_W-1:0];
                end
            end else if (m0 != '0) begin
                cmd.cnt        = m0[dss_pkg::CNT_W-1:0];
                n_segment_open = 1'b1;
                // Recheck the mismatching byte as a delimiter start.
                if (i_data_byte == dss_pkg::delim_at(i_delim_bytes, '0)) begin
                    n_match_count = dss_pkg::CNT_W'(1);
                end else begin
                    cmd.tail      = dss_pkg::TAIL_DATA;
                    n_match_count = '0;
                end
            end else begin
                cmd.tail       = dss_pkg::TAIL_DATA;
                n_match_count  = '0;
                n_segment_open = 1'b1;
            end
        end
    end

    // Drop commands that produce no results.
    assign o_push = accept && (cmd.cnt != '0 || cmd.tail != dss_pkg::TAIL_NONE);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_count  <= '0;
            r_segment_open <= 1'b0;
        end else if (accept) begin
            r_match_count  <= n_match_count;
            r_segment_open <= n_segment_open;
        end
    end

endmodule

// File: design/dss_queue.sv
// Two-entry command queue between the front and back ends.
module dss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dss_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output dss_pkg::t_cmd    o_head,
    output dss_pkg::t_q_stat o_stat
);

    dss_pkg::t_cmd r_entry [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: design/dss_back.sv
// Back end: expands commands into result beats behind an output register.
module dss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dss_pkg::t_cmd               i_head,
    input  dss_pkg::t_q_stat            i_q_stat,
    output logic                        o_pop,
    input  logic [dss_pkg::DELIM_W-1:0] i_delim_bytes,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [dss_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_segment_end,
    output logic                        o_last
);

    logic                       r_have, n_have;
    dss_pkg::t_cmd              r_cmd;
    logic [dss_pkg::CNT_W-1:0]  r_idx;
    logic                       r_out_valid;
    logic [dss_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                       r_byte_valid, n_byte_valid;
    logic                       r_segment_end, n_segment_end;
    logic                       r_last, n_last;
    logic                       advance;
    logic                       in_flush;
    logic                       finish;

    assign advance  = !r_out_valid || !i_out_stall;
    assign in_flush = (r_idx < r_cmd.cnt);

    always_comb begin
        if (in_flush) begin
            n_out_byte    = dss_pkg::delim_at(i_delim_bytes, r_idx);
            n_byte_valid  = 1'b1;
            n_segment_end = 1'b0;
            finish        = (r_idx == r_cmd.cnt - 3'd1) && (r_cmd.tail == dss_pkg::TAIL_NONE);
        end else begin
            n_byte_valid  = (r_cmd.tail == dss_pkg::TAIL_DATA);
            n_segment_end = (r_cmd.tail == dss_pkg::TAIL_END);
            n_out_byte    = n_byte_valid ? r_cmd.data : '0;
            finish        = 1'b1;
        end
        n_last = finish;
    end

    assign o_pop  = !i_q_stat.empty && (!r_have || (advance && finish));
    assign n_have = o_pop ? 1'b1 : ((advance && finish) ? 1'b0 : r_have);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_have <= n_have;
            if (o_pop) begin
                r_idx <= '0;
            end else if (advance && r_have) begin
                r_idx <= r_idx + 3'd1;
            end
            if (advance) begin
                r_out_valid <= r_have;
            end
        end
    end

    // Payload holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (advance && r_have) begin
            r_out_byte    <= n_out_byte;
            r_byte_valid  <= n_byte_valid;
            r_segment_end <= n_segment_end;
            r_last        <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_segment_end = r_segment_end;
    assign o_last        = r_last;

endmodule

// File: design/dss_checker.sv
// Port-level checker for the delimiter stream splitter, bound to the top level.
`include "delimiter_stream_splitter_defines.svh"

module dss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [dss_pkg::BYTE_W-1:0] o_out_byte,
    input logic                       o_byte_valid,
    input logic                       o_segment_end,
    input logic                       o_last
);

    `DSS_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `DSS_ASSERT(a_hold_stalled, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_byte_valid) && $stable(o_segment_end) && $stable(o_last), "stalled result changed")
    `DSS_ASSERT(a_one_kind, o_out_valid |-> (o_byte_valid ^ o_segment_end), "result is neither or both byte and end")
    `DSS_ASSERT(a_end_is_last, o_out_valid && o_segment_end |-> o_last && (o_out_byte == '0), "segment end not last or carries a byte")

endmodule

bind delimiter_stream_splitter dss_checker u_dss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_byte_valid  (o_byte_valid),
    .o_segment_end (o_segment_end),
    .o_last        (o_last)
);

// File: test/delimiter_stream_splitter_tb.sv
// Self-checking testbench for delimiter_stream_splitter: directed cases, random streams.
`timescale 1ns / 1ps

module delimiter_stream_splitter_tb;

    localparam logic [dss_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [dss_pkg::BYTE_W-1:0] data;
        logic                       vld;
        logic                       seg_end;
        logic                       last;
    } t_seg_beat;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic [dss_pkg::BYTE_W-1:0]    i_data_byte    = '0;
    logic                          i_end_of_input = 1'b0;
    logic                          i_out_stall    = 1'b0;
    logic                          i_cfg_valid    = 1'b0;
    logic [dss_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [dss_pkg::DELIM_W-1:0]   i_cfg_data     = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [dss_pkg::BYTE_W-1:0]    o_out_byte;
    logic                          o_byte_valid;
    logic                          o_segment_end;
    logic                          o_last;
    logic                          o_cfg_ready;

    // Splitter state as the block should hold it.
    logic [dss_pkg::DELIM_W-1:0] delim_word = dss_pkg::DELIM_BYTES_RESET;
    logic [dss_pkg::LEN_W-1:0]   delim_len  = dss_pkg::DELIM_LENGTH_RESET;
    logic [3:0]                  match_cnt  = '0;
    logic                        seg_open   = 1'b0;
    t_seg_beat                   seg_out_q[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int beat_cnt       = 0;
    int result_cnt     = 0;
    int end_cnt        = 0;
    int cfg_cnt        = 0;
    int bad_cnt        = 0;

    delimiter_stream_splitter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_segment_end  (o_segment_end),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    function automatic logic [dss_pkg::BYTE_W-1:0] delim_byte(input logic [3:0] idx);
        return delim_word[{idx[2:0], 3'b000} +: dss_pkg::BYTE_W];
    endfunction

    function automatic void put_beat(inout int n, input logic [dss_pkg::BYTE_W-1:0] data,
                                     input logic vld, input logic seg_end);
        t_seg_beat b;
        if (n >= dss_pkg::MAX_DELIM) begin
            return;
        end
        b.data    = data;
        b.vld     = vld;
        b.seg_end = seg_end;
        b.last    = 1'b0;
        seg_out_q.insert(seg_out_q.size(), b);
        n++;
    endfunction

    // Emit the held delimiter prefix as data, rebuilt from the current bytes.
    function automatic void flush_prefix(inout int n);
        for (int i = 0; i < match_cnt && i < 8; i++) begin
            put_beat(n, delim_byte(i[3:0]), 1'b1, 1'b0);
            seg_open = 1'b1;
        end
        match_cnt = '0;
    endfunction

    function automatic void cut_stream(input logic [dss_pkg::BYTE_W-1:0] b, input logic eoi);
        logic [3:0] len;
        logic       close;
        int         n;
        n = 0;
        if (delim_len == '0) begin
            len = 4'd1;
        end else if (delim_len > 4'd8) begin
            len = 4'd8;
        end else begin
            len = delim_len;
        end
        if (eoi) begin
            close = seg_open || (match_cnt != '0);
            flush_prefix(n);
            if (close) begin
                put_beat(n, '0, 1'b0, 1'b1);
            end
            seg_open = 1'b0;
        end else begin
            if (match_cnt >= len) begin
                flush_prefix(n);
            end
            if (b == delim_byte(match_cnt)) begin
                match_cnt++;
                if (match_cnt >= len) begin
                    put_beat(n, '0, 1'b0, 1'b1);
                    match_cnt = '0;
                    seg_open  = 1'b0;
                end
            end else if (match_cnt != '0) begin
                flush_prefix(n);
                // Recheck the mismatching byte as a fresh delimiter start.
                if (b == delim_byte(4'd0)) begin
                    match_cnt = 4'd1;
                end else begin
                    put_beat(n, b, 1'b1, 1'b0);
                    seg_open = 1'b1;
                end
            end else begin
                put_beat(n, b, 1'b1, 1'b0);
                seg_open = 1'b1;
            end
        end
        if (n > 0) begin
            seg_out_q[seg_out_q.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : chk_blk
        t_seg_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_cnt++;
            if (seg_out_q.size() == 0) begin
                $error("unexpected result beat: byte %02h vld %0b end %0b last %0b",
                       o_out_byte, o_byte_valid, o_segment_end, o_last);
                bad_cnt++;
            end else begin
                want = seg_out_q.pop_front();
                if (want.seg_end) begin
                    end_cnt++;
                end
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    bad_cnt++;
                end
                if (o_byte_valid !== want.vld) begin
                    $error("byte_valid: expected %0b, got %0b", want.vld, o_byte_valid);
                    bad_cnt++;
                end
                if (o_segment_end !== want.seg_end) begin
                    $error("segment_end: expected %0b, got %0b", want.seg_end, o_segment_end);
                    bad_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    bad_cnt++;
                end
            end
        end
    end

    task automatic send_beat(input logic [dss_pkg::BYTE_W-1:0] b, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_in_stall);
        cut_stream(b, eoi);
        beat_cnt++;
    endtask

    // Drop valid, drain all pending results, then give the pipeline time to empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (seg_out_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dss_pkg::DELIM_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == dss_pkg::REG_DELIM_BYTES) begin
            delim_word = val;
        end else if (idx == dss_pkg::REG_DELIM_LENGTH) begin
            delim_len = val[dss_pkg::LEN_W-1:0];
        end
        i_cfg_valid <= 1'b0;
        cfg_cnt++;
    endtask

    // Reset delimiter: empty segment on back-to-back newlines, end after full match.
    task automatic test_newline_default();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h0A, 1'b0);
        send_beat(8'h0A, 1'b0);
        send_beat(8'h5A, 1'b1);
    endtask

    // Two-byte delimiter: restart on repeated first byte, prefix flush on mismatch.
    task automatic test_two_byte();
        write_reg(dss_pkg::REG_DELIM_BYTES, 64'h0A0D);
        write_reg(dss_pkg::REG_DELIM_LENGTH, 64'd2);
        send_beat(8'h0D, 1'b0);
        send_beat(8'h0D, 1'b0);
        send_beat(8'h0A, 1'b0);
        send_beat(8'h0D, 1'b0);
        send_beat(8'h41, 1'b0);
    endtask

    // Length zero acts as one, length above eight acts as eight.
    task automatic test_length_limits();
        write_reg(dss_pkg::REG_DELIM_BYTES, '1);
        write_reg(dss_pkg::REG_DELIM_LENGTH, 64'd0);
        send_beat(8'hFF, 1'b0);
        write_reg(dss_pkg::REG_DELIM_BYTES, '0);
        write_reg(dss_pkg::REG_DELIM_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0 | 64'd12);
        repeat (7) send_beat(8'h00, 1'b0);
        // Seven held bytes plus the mismatching one: the widest burst.
        send_beat(8'h5A, 1'b0);
    endtask

    // Shrink the length while a longer prefix is held.
    task automatic test_shrink_mid_match();
        write_reg(dss_pkg::REG_DELIM_BYTES, 64'h6463_6261);
        write_reg(dss_pkg::REG_DELIM_LENGTH, 64'd4);
        send_beat(8'h61, 1'b0);
        send_beat(8'h62, 1'b0);
        send_beat(8'h63, 1'b0);
        write_reg(dss_pkg::REG_DELIM_LENGTH, 64'd2);
        send_beat(8'h78, 1'b0);
    endtask

    // Change the delimiter bytes while a prefix is held, then end the stream.
    task automatic test_bytes_changed_mid_match();
        write_reg(dss_pkg::REG_DELIM_LENGTH, 64'd4);
        send_beat(8'h61, 1'b0);
        send_beat(8'h62, 1'b0);
        write_reg(dss_pkg::REG_DELIM_BYTES, 64'h5A59_5857);
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [dss_pkg::DELIM_W-1:0] word;
        logic [dss_pkg::LEN_W-1:0]   len;
        logic [dss_pkg::BYTE_W-1:0]  b;
        int                          r;
        for (int seg = 0; seg < 8; seg++) begin
            case ($urandom_range(3))
                0: begin
                    for (int k = 0; k < dss_pkg::MAX_DELIM; k++) begin
                        word[k*8 +: 8] = $urandom_range(1) ? 8'h41 : 8'h42;
                    end
                end
                1: word = $urandom_range(1) ? '1 : '0;
                default: word = {$urandom, $urandom};
            endcase
            if (seg == 0) begin
                len = 4'd1;
            end else if (seg == 1) begin
                len = 4'd8;
            end else if ($urandom_range(4) == 0) begin
                len = 4'($urandom_range(15));
            end else begin
                len = 4'($urandom_range(1, 8));
            end
            write_reg(dss_pkg::REG_DELIM_BYTES, word);
            write_reg(dss_pkg::REG_DELIM_LENGTH, {$urandom, $urandom} & ~64'hF | 64'(len));
            case (seg % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            for (int k = 0; k < 51; k++) begin
                r = $urandom_range(99);
                b = 8'($urandom_range(255));
                if (r < 4) begin
                    send_beat(b, 1'b1);
                end else if (r < 45) begin
                    send_beat(delim_byte(match_cnt), 1'b0);
                end else if (r < 60) begin
                    send_beat(delim_byte(4'd0), 1'b0);
                end else if (r < 70) begin
                    send_beat(delim_byte(4'($urandom_range(7))), 1'b0);
                end else begin
                    send_beat(b, 1'b0);
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_newline_default();
        test_two_byte();
        test_length_limits();
        test_shrink_mid_match();
        test_bytes_changed_mid_match();
        test_random_streams();
        i_in_valid <= 1'b0;
        sink_stall_pct = 0;
        for (int w = 0; w < 20000 && seg_out_q.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (seg_out_q.size() != 0) begin
            $error("%0d result beats never arrived", seg_out_q.size());
            bad_cnt++;
        end
        $display("Sent %0d input beats across %0d register writes and four idling mixes;",
                 beat_cnt, cfg_cnt);
        $display("checked %0d result beats, %0d of them segment ends.", result_cnt, end_cnt);
        if (bad_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: delimiter_stream_splitter.f
+incdir+design
design/dss_pkg.sv
design/dss_front.sv
design/dss_queue.sv
design/dss_back.sv
design/delimiter_stream_splitter.sv
design/dss_checker.sv
test/delimiter_stream_splitter_tb.sv
